[rtl/fir_pkg.sv]
// shared types and constants for the direct-form fir filter
// no dependencies; used by fir_mac and fir_filter_direct_form
`default_nettype none

package fir_pkg;

    localparam int MAX_TAPS     = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int COEF_BITS    = 16;
    localparam int TAP_IDX_BITS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_BITS     = $clog2(MAX_TAPS + 1);
    localparam int ACC_BITS     = SAMPLE_BITS + COEF_BITS + TAP_IDX_BITS;
    localparam int TAP_CFG_BITS = 7;
    localparam int TAP_FLD_BITS = 6;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX =
        {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
        {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_FILTER = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctrl;

endpackage

`default_nettype wire

[rtl/fir_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                            i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/fir_mac.sv]
// shared multiply-accumulate unit with rounding and saturation of the sum
// depends on fir_pkg
`default_nettype none

module fir_mac (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire fir_pkg::t_mac_ctrl                       i_ctrl,
    input  wire logic      [fir_pkg::COEF_BITS-1:0]       i_coef,
    input  wire logic      [fir_pkg::SAMPLE_BITS-1:0]     i_sample,
    output logic                                          o_busy,
    output logic signed    [fir_pkg::SAMPLE_BITS-1:0]     o_result,
    output logic                                          o_sat
);

    localparam int PROD_BITS = fir_pkg::SAMPLE_BITS + fir_pkg::COEF_BITS;
    localparam int RND_BITS  = fir_pkg::ACC_BITS + 1;
    localparam logic signed [RND_BITS-1:0] ROUND_HALF =
        RND_BITS'(1) << (fir_pkg::COEF_BITS - 2);
    localparam logic signed [RND_BITS-1:0] MAX_EXT = RND_BITS'(fir_pkg::SAMPLE_MAX);
    localparam logic signed [RND_BITS-1:0] MIN_EXT = RND_BITS'(fir_pkg::SAMPLE_MIN);

    logic signed [PROD_BITS-1:0]         r_prod;
    logic                                r_prod_vld;
    logic signed [fir_pkg::ACC_BITS-1:0] r_acc;
    logic signed [RND_BITS-1:0]          rnd_sum;
    logic signed [RND_BITS-1:0]          rnd_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else if (i_ctrl.clear) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= i_ctrl.valid;
            if (r_prod_vld) begin
                r_acc <= r_acc + fir_pkg::ACC_BITS'(r_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_coef) * $signed(i_sample);
    end

    // round half up, then clip to sample range
    always_comb begin
        rnd_sum   = RND_BITS'(r_acc) + ROUND_HALF;
        rnd_shift = rnd_sum >>> (fir_pkg::COEF_BITS - 1);
        if (rnd_shift > MAX_EXT) begin
            o_result = fir_pkg::SAMPLE_MAX;
            o_sat    = 1'b1;
        end else if (rnd_shift < MIN_EXT) begin
            o_result = fir_pkg::SAMPLE_MIN;
            o_sat    = 1'b1;
        end else begin
            o_result = rnd_shift[fir_pkg::SAMPLE_BITS-1:0];
            o_sat    = 1'b0;
        end
    end

    assign o_busy = r_prod_vld;

endmodule

`default_nettype wire

[rtl/fir_filter_direct_form.sv]
// direct-form fir filter top level: sequencer, coefficient and history rams
// depends on fir_pkg, fir_ram, fir_mac
//
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_ready   opcode, tap_index, coefficient, sample,
//                                               start_of_block
// out      output     o_out_valid / i_out_ready filtered, saturated
// cfg      input      i_cfg_valid / o_cfg_ready tap_count
//
// a load beat leaves the sequencer idle; a filter beat runs states run, drain, finish, where
// taps is min(tap_count, 64, samples since start of block); one tap per cycle through the mac
// reset is synchronous; history needs no clear, only slots of the current block are read
// a finished result waits in the output register; the next result stalls until it is taken
`default_nettype none

module fir_filter_direct_form (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic                                   i_opcode,
    input  wire logic        [fir_pkg::TAP_FLD_BITS-1:0] i_tap_index,
    input  wire logic signed [fir_pkg::COEF_BITS-1:0]   i_coefficient,
    input  wire logic signed [fir_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                                   i_start_of_block,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed      [fir_pkg::SAMPLE_BITS-1:0] o_filtered,
    output logic                                        o_saturated,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic        [fir_pkg::TAP_CFG_BITS-1:0] i_cfg_tap_count
);

    localparam int IB = fir_pkg::TAP_IDX_BITS;
    localparam int CB = fir_pkg::CNT_BITS;

    fir_pkg::t_state r_state;
    fir_pkg::t_state n_state;

    logic [fir_pkg::TAP_CFG_BITS-1:0]     r_tap_count;
    logic [IB-1:0]                        r_head;
    logic [IB-1:0]                        n_head;
    logic [IB-1:0]                        r_rd_ptr;
    logic [CB-1:0]                        r_sib;
    logic [CB-1:0]                        n_sib;
    logic [CB-1:0]                        r_taps;
    logic [CB-1:0]                        n_taps;
    logic [CB-1:0]                        cfg_taps;
    logic [CB-1:0]                        r_k;
    logic                                 r_rd_vld;
    logic                                 r_out_vld;
    logic signed [fir_pkg::SAMPLE_BITS-1:0] r_filtered;
    logic                                 r_saturated;

    logic in_beat;
    logic load_beat;
    logic filter_beat;
    logic coef_wr_en;
    logic issue;
    logic fin_load;

    logic [fir_pkg::COEF_BITS-1:0]   coef_rd;
    logic [fir_pkg::SAMPLE_BITS-1:0] hist_rd;

    fir_pkg::t_mac_ctrl mac_ctrl;
    logic mac_busy;
    logic signed [fir_pkg::SAMPLE_BITS-1:0] mac_result;
    logic mac_sat;

    assign in_beat     = i_in_valid && o_in_ready;
    assign load_beat   = in_beat && (fir_pkg::t_opcode'(i_opcode) == fir_pkg::OP_LOAD);
    assign filter_beat = in_beat && (fir_pkg::t_opcode'(i_opcode) == fir_pkg::OP_FILTER);
    assign coef_wr_en  = load_beat && (int'(i_tap_index) < fir_pkg::MAX_TAPS);

    // slot bookkeeping for a new sample
    always_comb begin
        if (int'(r_head) == fir_pkg::MAX_TAPS - 1) begin
            n_head = '0;
        end else begin
            n_head = r_head + IB'(1);
        end
        if (i_start_of_block) begin
            n_sib = CB'(1);
        end else if (int'(r_sib) < fir_pkg::MAX_TAPS) begin
            n_sib = r_sib + CB'(1);
        end else begin
            n_sib = r_sib;
        end
        if (int'(r_tap_count) > fir_pkg::MAX_TAPS) begin
            cfg_taps = CB'(fir_pkg::MAX_TAPS);
        end else begin
            cfg_taps = CB'(r_tap_count);
        end
        n_taps = (cfg_taps < n_sib) ? cfg_taps : n_sib;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fir_pkg::ST_IDLE: begin
                if (filter_beat) begin
                    n_state = fir_pkg::ST_RUN;
                end
            end
            fir_pkg::ST_RUN: begin
                if (r_k == r_taps) begin
                    n_state = fir_pkg::ST_DRAIN;
                end
            end
            fir_pkg::ST_DRAIN: begin
                if (!r_rd_vld && !mac_busy) begin
                    n_state = fir_pkg::ST_FINISH;
                end
            end
            fir_pkg::ST_FINISH: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = fir_pkg::ST_IDLE;
                end
            end
            default: n_state = fir_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == fir_pkg::ST_IDLE);
        issue      = (r_state == fir_pkg::ST_RUN) && (r_k != r_taps);
        fin_load   = (r_state == fir_pkg::ST_FINISH) && (!r_out_vld || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fir_pkg::ST_IDLE;
            r_tap_count <= fir_pkg::TAP_CFG_BITS'(1);
            r_head      <= '0;
            r_sib       <= '0;
            r_taps      <= '0;
            r_k         <= '0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tap_count <= i_cfg_tap_count;
            end
            if (filter_beat) begin
                r_head <= n_head;
                r_sib  <= n_sib;
                r_taps <= n_taps;
                r_k    <= '0;
            end else if (issue) begin
                r_k <= r_k + CB'(1);
            end
            if (fin_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // read pointer walks back from the newest sample
    always_ff @(posedge i_clk) begin
        if (filter_beat) begin
            r_rd_ptr <= n_head;
        end else if (issue) begin
            if (r_rd_ptr == '0) begin
                r_rd_ptr <= IB'(fir_pkg::MAX_TAPS - 1);
            end else begin
                r_rd_ptr <= r_rd_ptr - IB'(1);
            end
        end
        if (fin_load) begin
            r_filtered  <= mac_result;
            r_saturated <= mac_sat;
        end
    end

    fir_ram #(
        .WIDTH (fir_pkg::COEF_BITS),
        .DEPTH (fir_pkg::MAX_TAPS)
    ) u_coef_ram (
        .i_clk     (i_clk),
        .i_wr_en   (coef_wr_en),
        .i_wr_addr (IB'(i_tap_index)),
        .i_wr_data (fir_pkg::COEF_BITS'(i_coefficient)),
        .i_rd_addr (r_k[IB-1:0]),
        .o_rd_data (coef_rd)
    );

    fir_ram #(
        .WIDTH (fir_pkg::SAMPLE_BITS),
        .DEPTH (fir_pkg::MAX_TAPS)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (filter_beat),
        .i_wr_addr (n_head),
        .i_wr_data (fir_pkg::SAMPLE_BITS'(i_sample)),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (hist_rd)
    );

    assign mac_ctrl = '{clear: filter_beat, valid: r_rd_vld};

    fir_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_coef   (coef_rd),
        .i_sample (hist_rd),
        .o_busy   (mac_busy),
        .o_result (mac_result),
        .o_sat    (mac_sat)
    );

    assign o_out_valid = r_out_vld;
    assign o_filtered  = r_filtered;
    assign o_saturated = r_saturated;
    assign o_cfg_ready = 1'b1;

    a_taps_within_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taps <= r_sib)
        else $error("tap count exceeds samples in block");

    a_k_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fir_pkg::ST_RUN) |-> (r_k <= r_taps))
        else $error("tap counter overran");

    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fir_pkg::ST_FINISH) |-> (!r_rd_vld && !mac_busy))
        else $error("result taken before mac drained");

    a_sat_clips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_filtered == fir_pkg::SAMPLE_MAX || o_filtered == fir_pkg::SAMPLE_MIN))
        else $error("saturated flag without clipped value");

endmodule

`default_nettype wire
